// ===== sv/hkp_pkg.sv =====
// ----------------------------------------------------------------------------
// hkp_pkg: shared types and constants of the key path parser
// Item types, character classes, parser phases and default sizes.
// ----------------------------------------------------------------------------
package hkp_pkg;

	localparam int unsigned MAX_DEPTH_DEF   = 16;
	localparam int unsigned MAX_LENGTH_DEF  = 61;
	localparam int unsigned QUEUE_DEPTH_DEF = 2;
	localparam int unsigned MAX_DIGITS      = 11;

	localparam logic [31:0] HARDENED = 32'h8000_0000;

	localparam logic [7:0] CH_LOWER_M = 8'h6D;
	localparam logic [7:0] CH_UPPER_M = 8'h4D;
	localparam logic [7:0] CH_SLASH   = 8'h2F;
	localparam logic [7:0] CH_APOS    = 8'h27;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_NINE    = 8'h39;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} hkp_in_t;

	typedef struct packed {
		logic        is_final;
		logic [31:0] child_index;
		logic [3:0]  level;
		logic        ok;
		logic        is_private;
		logic [4:0]  depth;
	} hkp_out_t;

	typedef enum logic [2:0] {
		CL_LOWER_M,
		CL_UPPER_M,
		CL_SLASH,
		CL_DIGIT,
		CL_APOS,
		CL_OTHER
	} hkp_cls_t;

	typedef struct packed {
		hkp_cls_t   cls;
		logic [3:0] digit;
		logic       last;
	} hkp_tok_t;

	typedef enum logic [2:0] {
		PH_START,
		PH_SLASH,
		PH_SKIP,
		PH_DIGITS,
		PH_DONE
	} hkp_phase_t;

	typedef struct packed {
		logic hold_valid;
		logic mid_path;
	} hkp_stat_t;

endpackage

// ===== sv/hkp_front.sv =====
// ----------------------------------------------------------------------------
// hkp_front: character intake and classification
// Registers each accepted character as a class, a digit value and the last flag.
// ----------------------------------------------------------------------------
module hkp_front import hkp_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  hkp_in_t  in_item,
	output logic     tok_valid,
	input  logic     tok_ready,
	output hkp_tok_t tok
);

	logic     valid_s1;
	hkp_tok_t tok_s1;
	hkp_tok_t tok_c;

	always_comb begin
		tok_c.digit = in_item.ch[3:0];
		tok_c.last  = in_item.last;
		if (in_item.ch >= CH_ZERO && in_item.ch <= CH_NINE) begin
			tok_c.cls = CL_DIGIT;
		end else if (in_item.ch == CH_SLASH) begin
			tok_c.cls = CL_SLASH;
		end else if (in_item.ch == CH_APOS) begin
			tok_c.cls = CL_APOS;
		end else if (in_item.ch == CH_LOWER_M) begin
			tok_c.cls = CL_LOWER_M;
		end else if (in_item.ch == CH_UPPER_M) begin
			tok_c.cls = CL_UPPER_M;
		end else begin
			tok_c.cls = CL_OTHER;
		end
	end

	assign in_ready  = !valid_s1 || tok_ready;
	assign tok_valid = valid_s1;
	assign tok       = tok_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (tok_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			tok_s1 <= tok_c;
		end
	end

endmodule

// ===== sv/hkp_queue.sv =====
// ----------------------------------------------------------------------------
// hkp_queue: short queue of classified items
// Decouples the intake from the parser so that each side stalls on its own.
// ----------------------------------------------------------------------------
module hkp_queue import hkp_pkg::*; #(
	parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     wr_valid,
	output logic     wr_ready,
	input  hkp_tok_t wr_tok,
	output logic     rd_valid,
	input  logic     rd_ready,
	output hkp_tok_t rd_tok
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	hkp_tok_t             slot_q [DEPTH];
	logic     [PTR_W-1:0] wr_ptr_q;
	logic     [PTR_W-1:0] rd_ptr_q;
	logic     [CNT_W-1:0] count_q;
	logic                 push;
	logic                 pop;

	assign wr_ready = count_q < CNT_W'(DEPTH);
	assign rd_valid = count_q != '0;
	assign rd_tok   = slot_q[rd_ptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wr_tok;
		end
	end

endmodule

// ===== sv/hkp_back.sv =====
// ----------------------------------------------------------------------------
// hkp_back: path parser state machine and result output
// Runs one classified item per cycle unless stalled; emits components, final status.
// ----------------------------------------------------------------------------
module hkp_back import hkp_pkg::*; #(
	parameter int unsigned MAX_DEPTH  = MAX_DEPTH_DEF,
	parameter int unsigned MAX_LENGTH = MAX_LENGTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      tok_valid,
	output logic      tok_ready,
	input  hkp_tok_t  tok,
	output logic      out_valid,
	input  logic      out_ready,
	output hkp_out_t  out_item,
	output hkp_stat_t stat
);

	localparam int unsigned CHAR_W = $clog2(MAX_LENGTH + 1);
	localparam int unsigned CNT_W  = $clog2(MAX_DEPTH + 1);

	hkp_phase_t              phase_q, phase_n;
	logic       [31:0]       acc_q, acc_n;
	logic       [3:0]        dcnt_q, dcnt_n;
	logic       [CHAR_W-1:0] ccnt_q, ccnt_n;
	logic       [CNT_W-1:0]  comp_q, comp_n;
	logic                    priv_q, priv_n;
	logic                    fail_q, fail_n;

	logic                    emit;
	logic       [31:0]       emit_val;
	hkp_out_t                comp_item;
	hkp_out_t                fin_item;
	logic                    proc;

	logic                    out_valid_q;
	hkp_out_t                out_q;
	logic                    hold_valid_q;
	hkp_out_t                hold_q;

	always_comb begin
		phase_n  = phase_q;
		acc_n    = acc_q;
		dcnt_n   = dcnt_q;
		ccnt_n   = ccnt_q;
		comp_n   = comp_q;
		priv_n   = priv_q;
		fail_n   = fail_q;
		emit     = 1'b0;
		emit_val = acc_q;

		if (!fail_q) begin
			if (ccnt_q >= CHAR_W'(MAX_LENGTH)) begin
				fail_n = 1'b1;
			end else begin
				ccnt_n = ccnt_q + 1'b1;
			end
		end

		if (!fail_n) begin
			case (phase_q)
				PH_START: begin
					case (tok.cls)
						CL_LOWER_M: begin
							priv_n  = 1'b1;
							phase_n = PH_SLASH;
						end
						CL_UPPER_M: begin
							priv_n  = 1'b0;
							phase_n = PH_SLASH;
						end
						default: begin
							fail_n = 1'b1;
						end
					endcase
				end
				PH_SLASH: begin
					if (tok.cls == CL_SLASH) begin
						if (comp_q >= CNT_W'(MAX_DEPTH)) begin
							fail_n = 1'b1;
						end else begin
							phase_n = PH_SKIP;
						end
					end else begin
						phase_n = PH_DONE;
					end
				end
				PH_SKIP: begin
					if (tok.cls == CL_DIGIT) begin
						acc_n   = 32'(tok.digit);
						dcnt_n  = 4'd1;
						phase_n = PH_DIGITS;
					end
				end
				PH_DIGITS: begin
					if (tok.cls == CL_DIGIT) begin
						if (dcnt_q >= 4'(MAX_DIGITS)) begin
							fail_n = 1'b1;
						end else begin
							acc_n  = (acc_q << 3) + (acc_q << 1) + 32'(tok.digit);
							dcnt_n = dcnt_q + 1'b1;
						end
					end else if (tok.cls == CL_APOS) begin
						emit     = 1'b1;
						emit_val = acc_q + HARDENED;
						comp_n   = comp_q + 1'b1;
						phase_n  = PH_SLASH;
					end else begin
						emit     = 1'b1;
						emit_val = acc_q;
						comp_n   = comp_q + 1'b1;
						if (tok.cls == CL_SLASH) begin
							if (comp_n >= CNT_W'(MAX_DEPTH)) begin
								fail_n = 1'b1;
							end else begin
								phase_n = PH_SKIP;
							end
						end else begin
							phase_n = PH_DONE;
						end
					end
				end
				default: begin
				end
			endcase
		end

		if (tok.last && !fail_n && phase_n == PH_DIGITS) begin
			emit     = 1'b1;
			emit_val = acc_n;
			comp_n   = comp_n + 1'b1;
		end

		comp_item.is_final    = 1'b0;
		comp_item.child_index = emit_val;
		comp_item.level       = 4'(comp_q);
		comp_item.ok          = 1'b0;
		comp_item.is_private  = 1'b0;
		comp_item.depth       = '0;

		fin_item.is_final    = 1'b1;
		fin_item.child_index = '0;
		fin_item.level       = '0;
		fin_item.ok          = !fail_n && phase_n != PH_SKIP && phase_n != PH_START;
		fin_item.is_private  = priv_n;
		fin_item.depth       = 5'(comp_n);

		if (tok.last) begin
			phase_n = PH_START;
			acc_n   = '0;
			dcnt_n  = '0;
			ccnt_n  = '0;
			comp_n  = '0;
			priv_n  = 1'b0;
			fail_n  = 1'b0;
		end
	end

	assign tok_ready = !hold_valid_q && (!out_valid_q || out_ready);
	assign proc      = tok_valid && tok_ready;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	assign stat.hold_valid = hold_valid_q;
	assign stat.mid_path   = phase_q != PH_START;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_START;
			acc_q        <= '0;
			dcnt_q       <= '0;
			ccnt_q       <= '0;
			comp_q       <= '0;
			priv_q       <= 1'b0;
			fail_q       <= 1'b0;
			out_valid_q  <= 1'b0;
			hold_valid_q <= 1'b0;
		end else begin
			if (proc) begin
				phase_q <= phase_n;
				acc_q   <= acc_n;
				dcnt_q  <= dcnt_n;
				ccnt_q  <= ccnt_n;
				comp_q  <= comp_n;
				priv_q  <= priv_n;
				fail_q  <= fail_n;
				if (emit || tok.last) begin
					out_valid_q <= 1'b1;
				end else begin
					out_valid_q <= 1'b0;
				end
				if (emit && tok.last) begin
					hold_valid_q <= 1'b1;
				end
			end else if (out_valid_q && out_ready) begin
				if (hold_valid_q) begin
					hold_valid_q <= 1'b0;
				end else begin
					out_valid_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (proc) begin
			if (emit) begin
				out_q <= comp_item;
				if (tok.last) begin
					hold_q <= fin_item;
				end
			end else if (tok.last) begin
				out_q <= fin_item;
			end
		end else if (out_valid_q && out_ready && hold_valid_q) begin
			out_q <= hold_q;
		end
	end

endmodule

// ===== sv/hd_key_path_parser_core.sv =====
// ----------------------------------------------------------------------------
// hd_key_path_parser_core: streaming key derivation path parser
// Parses m/44'/0'/0 style paths a character at a time, emits components and
// a final status per path.
// ----------------------------------------------------------------------------
// channel  dir  handshake               item
// in       in   in_valid / in_ready     in_item  : ch, last
// out      out  out_valid / out_ready   out_item : is_final, child_index, level,
//                                                  ok, is_private, depth
//
// One character per cycle sustained while out_ready is high; the parser state
// machine in hkp_back takes one item a cycle.
// A last character that closes a pending component gives two items and holds
// the parser while the second drains.
// Input to result passes the intake register, a queue slot and the output register.
// arst_n clears all control state; the block needs no warm-up after reset.
// A stalled output fills the queue, then in_ready falls.
// ----------------------------------------------------------------------------
module hd_key_path_parser_core import hkp_pkg::*; #(
	parameter int unsigned MAX_DEPTH   = MAX_DEPTH_DEF,
	parameter int unsigned MAX_LENGTH  = MAX_LENGTH_DEF,
	parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  hkp_in_t  in_item,
	output logic     out_valid,
	input  logic     out_ready,
	output hkp_out_t out_item
);

	logic      f_valid;
	logic      f_ready;
	hkp_tok_t  f_tok;
	logic      q_valid;
	logic      q_ready;
	hkp_tok_t  q_tok;
	hkp_stat_t stat;

	hkp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.tok_valid (f_valid),
		.tok_ready (f_ready),
		.tok       (f_tok)
	);

	hkp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (f_valid),
		.wr_ready (f_ready),
		.wr_tok   (f_tok),
		.rd_valid (q_valid),
		.rd_ready (q_ready),
		.rd_tok   (q_tok)
	);

	hkp_back #(
		.MAX_DEPTH  (MAX_DEPTH),
		.MAX_LENGTH (MAX_LENGTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.tok_valid (q_valid),
		.tok_ready (q_ready),
		.tok       (q_tok),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item),
		.stat      (stat)
	);

	a_hold_behind_comp: assert property (@(posedge clk) disable iff (!arst_n)
		stat.hold_valid |-> out_valid && !out_item.is_final)
		else $error("held status without a component ahead of it");

	a_hold_after_reset: assert property (@(posedge clk) disable iff (!arst_n)
		stat.hold_valid |-> !stat.mid_path)
		else $error("parser state not cleared while status is held");

	a_comp_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_item.is_final |->
			!out_item.ok && !out_item.is_private && out_item.depth == 5'd0)
		else $error("status fields set in a component item");

endmodule

// ===== tb/tb_hd_key_path_parser_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_hd_key_path_parser_core: self-checking bench for the key path parser
// Feeds directed and random derivation paths a character at a time, predicts
// every component and final status in a local parser model, and compares each
// result item in order under random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_hd_key_path_parser_core;
	import hkp_pkg::*;

	localparam int unsigned CHAR_TARGET = 1900;

	logic     clk       = 1'b0;
	logic     arst_n    = 1'b0;
	logic     in_valid  = 1'b0;
	logic     in_ready;
	hkp_in_t  in_item   = '0;
	logic     out_valid;
	logic     out_ready = 1'b0;
	hkp_out_t out_item;

	hkp_in_t    char_queue[$];
	logic [7:0] path_buf[$];
	hkp_out_t   due_results[$];

	int unsigned n_total    = 0;
	int unsigned n_sent     = 0;
	int unsigned hold_left  = 0;
	bit          hold_done  = 1'b0;
	int unsigned n_errors   = 0;

	hkp_phase_t  path_phase    = PH_START;
	logic [31:0] path_acc      = '0;
	int unsigned path_ndigits  = 0;
	int unsigned path_nchars   = 0;
	int unsigned path_depth    = 0;
	bit          path_private  = 1'b0;
	bit          path_rejected = 1'b0;

	hd_key_path_parser_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	always #2 clk = ~clk;

	function automatic int unsigned send_idle_pct();
		if (n_sent < n_total / 3)
			return 25;
		else if (n_sent < 2 * n_total / 3)
			return 48;
		return 0;
	endfunction

	function automatic int unsigned recv_stall_pct();
		if (n_sent < n_total / 3)
			return 48;
		else if (n_sent < 2 * n_total / 3)
			return 25;
		return 0;
	endfunction

	// ---------------------------------------------------------------- prediction
	task automatic emit_component(input logic [31:0] value);
		hkp_out_t r;
		r             = '0;
		r.child_index = value;
		r.level       = path_depth[3:0];
		due_results.push_back(r);
		path_depth++;
	endtask

	task automatic open_component();
		if (path_depth >= MAX_DEPTH_DEF)
			path_rejected = 1'b1;
		else
			path_phase = PH_SKIP;
	endtask

	task automatic parse_char(input hkp_in_t it);
		logic [7:0] c;
		bit         is_dig;
		logic [3:0] dv;
		hkp_out_t   st;
		c      = it.ch;
		is_dig = (c >= CH_ZERO) && (c <= CH_NINE);
		dv     = 4'(c - CH_ZERO);

		if (!path_rejected) begin
			if (path_nchars >= MAX_LENGTH_DEF)
				path_rejected = 1'b1;
			else
				path_nchars++;
		end

		if (!path_rejected) begin
			case (path_phase)
				PH_START: begin
					if (c == CH_LOWER_M) begin
						path_private = 1'b1;
						path_phase   = PH_SLASH;
					end else if (c == CH_UPPER_M) begin
						path_private = 1'b0;
						path_phase   = PH_SLASH;
					end else begin
						path_rejected = 1'b1;
					end
				end
				PH_SLASH: begin
					if (c == CH_SLASH)
						open_component();
					else
						path_phase = PH_DONE;
				end
				PH_SKIP: begin
					if (is_dig) begin
						path_acc     = {28'd0, dv};
						path_ndigits = 1;
						path_phase   = PH_DIGITS;
					end
				end
				PH_DIGITS: begin
					if (is_dig) begin
						if (path_ndigits >= MAX_DIGITS) begin
							path_rejected = 1'b1;
						end else begin
							path_acc = path_acc * 32'd10 + {28'd0, dv};
							path_ndigits++;
						end
					end else if (c == CH_APOS) begin
						emit_component(path_acc + HARDENED);
						path_phase = PH_SLASH;
					end else begin
						emit_component(path_acc);
						if (c == CH_SLASH)
							open_component();
						else
							path_phase = PH_DONE;
					end
				end
				default: begin
				end
			endcase
		end

		if (it.last) begin
			if (!path_rejected && path_phase == PH_DIGITS)
				emit_component(path_acc);
			st            = '0;
			st.is_final   = 1'b1;
			st.ok         = !path_rejected && path_phase != PH_SKIP && path_phase != PH_START;
			st.is_private = path_private;
			st.depth      = path_depth[4:0];
			due_results.push_back(st);
			path_phase    = PH_START;
			path_acc      = '0;
			path_ndigits  = 0;
			path_nchars   = 0;
			path_depth    = 0;
			path_private  = 1'b0;
			path_rejected = 1'b0;
		end
	endtask

	// ---------------------------------------------------------------- stimulus
	task automatic add_byte(input logic [7:0] c);
		path_buf.push_back(c);
	endtask

	task automatic add_str(input string s);
		for (int i = 0; i < s.len(); i++)
			path_buf.push_back(s[i]);
	endtask

	task automatic add_digits(input int unsigned n);
		for (int unsigned i = 0; i < n; i++)
			path_buf.push_back(CH_ZERO + 8'($urandom_range(9)));
	endtask

	task automatic add_non_digit();
		logic [7:0] c;
		c = 8'($urandom_range(255));
		if (c >= CH_ZERO && c <= CH_NINE)
			c = c ^ 8'h40;
		path_buf.push_back(c);
	endtask

	task automatic queue_path();
		hkp_in_t it;
		while (path_buf.size() != 0) begin
			it.ch   = path_buf.pop_front();
			it.last = (path_buf.size() == 0);
			char_queue.push_back(it);
		end
	endtask

	task automatic gen_path();
		int unsigned r;
		int unsigned ncomp;
		int unsigned ndig;
		r = $urandom_range(99);
		if (r < 8) begin
			repeat ($urandom_range(8, 1)) add_byte(8'($urandom_range(255)));
		end else begin
			if (r < 12)
				add_byte(8'($urandom_range(255)));
			else
				add_byte($urandom_range(1) ? CH_LOWER_M : CH_UPPER_M);
			ncomp = ($urandom_range(9) == 0) ? $urandom_range(17, 10) : $urandom_range(6);
			for (int unsigned k = 0; k < ncomp; k++) begin
				add_byte(CH_SLASH);
				if ($urandom_range(7) == 0)
					repeat ($urandom_range(3, 1)) add_non_digit();
				ndig = ($urandom_range(9) == 0) ? $urandom_range(12, 10) : $urandom_range(4, 1);
				if ($urandom_range(15) == 0)
					repeat (ndig) add_byte(CH_NINE);
				else
					add_digits(ndig);
				if ($urandom_range(1))
					add_byte(CH_APOS);
			end
			case ($urandom_range(9))
				0: add_byte(CH_SLASH);
				1: begin
					add_non_digit();
					repeat ($urandom_range(3)) add_byte(8'($urandom_range(255)));
				end
				2: add_byte(8'($urandom_range(255)));
				default: begin
				end
			endcase
		end
		queue_path();
	endtask

	initial begin
		add_str("m");                     queue_path();
		add_str("M");                     queue_path();
		add_str("x/1");                   queue_path();
		add_str("m/");                    queue_path();
		add_str("M/abc");                 queue_path();
		add_str("m/44'/0'/0");            queue_path();
		add_str("M/4294967295'/0'");      queue_path();
		add_str("m/99999999999");         queue_path();
		add_str("m/123456789012/5");      queue_path();
		add_str("m/1x/2");                queue_path();
		add_str("M/7'9/3");               queue_path();
		add_str("mX/4");                  queue_path();
		add_str("m/8/");                  queue_path();
		add_str("m/");
		add_byte(8'hFF);
		add_byte(8'h00);
		add_str("5'");                    queue_path();
		add_str("m");
		repeat (16) add_str("/1");        queue_path();
		add_str("M");
		repeat (17) add_str("/2'");       queue_path();
		add_str("m/");
		repeat (58) add_byte("a");
		add_str("7");                     queue_path();
		add_str("m/");
		repeat (57) add_byte("a");
		add_str("123");                   queue_path();

		while (char_queue.size() < CHAR_TARGET)
			gen_path();
		n_total = char_queue.size();

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		while (char_queue.size() != 0 || in_valid)
			@(posedge clk);
		while (due_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (n_errors == 0)
			$display("[hd_key_path_parser_core] OK");
		else
			$display("[hd_key_path_parser_core] ERROR");
		$finish;
	end

	initial begin
		#800us;
		$display("[hd_key_path_parser_core] ERROR");
		$finish;
	end

	// ---------------------------------------------------------------- driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_item  <= '0;
			n_sent   <= 0;
		end else begin
			if (in_valid && in_ready)
				n_sent <= n_sent + 1;
			if (!in_valid || in_ready) begin
				if (char_queue.size() != 0 && $urandom_range(99) >= send_idle_pct()) begin
					in_valid <= 1'b1;
					in_item  <= char_queue.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off so that the block backs up into its input
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (!hold_done && n_sent >= 400) begin
			hold_left <= 300;
			hold_done <= 1'b1;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_ready <= 1'b0;
		else if (hold_left != 0)
			out_ready <= 1'b0;
		else
			out_ready <= ($urandom_range(99) >= recv_stall_pct());
	end

	// ---------------------------------------------------------------- monitor
	task automatic check_field(input string name, input logic [31:0] exp_v,
			input logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch, expected %0h, got %0h", $realtime, name, exp_v, act_v);
			n_errors++;
		end
	endtask

	always @(posedge clk) begin
		hkp_out_t want;
		if (arst_n) begin
			if (in_valid && in_ready)
				parse_char(in_item);
			if (out_valid && out_ready) begin
				if (due_results.size() == 0) begin
					$display("%0t: unexpected result, expected none, got %h", $realtime,
						out_item);
					n_errors++;
				end else begin
					want = due_results.pop_front();
					check_field("is_final", 32'(want.is_final), 32'(out_item.is_final));
					check_field("child_index", want.child_index, out_item.child_index);
					check_field("level", 32'(want.level), 32'(out_item.level));
					check_field("ok", 32'(want.ok), 32'(out_item.ok));
					check_field("is_private", 32'(want.is_private), 32'(out_item.is_private));
					check_field("depth", 32'(want.depth), 32'(out_item.depth));
				end
			end
		end
	end

endmodule

// ===== files.f =====
sv/hkp_pkg.sv
sv/hkp_front.sv
sv/hkp_queue.sv
sv/hkp_back.sv
sv/hd_key_path_parser_core.sv
tb/tb_hd_key_path_parser_core.sv
